>>> sv/nirq_pkg.sv
`default_nettype none
package nirq_pkg;

   localparam int unsigned NUM_SLOTS = 7;

   typedef enum logic [1:0] {
      REQ_READ      = 2'd0,
      REQ_WRITE     = 2'd1,
      REQ_IRQ_SET   = 2'd2,
      REQ_IRQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_CHASSIS_MODEL = 1'd0,
      CSR_CARD_PRESENT  = 1'd1
   } csr_index_type;

   localparam logic [1:0] MODEL_SMALL  = 2'd0;
   localparam logic [1:0] MODEL_MEDIUM = 2'd1;
   localparam logic [1:0] MODEL_LARGE  = 2'd2;

   localparam logic [17:0] ADDR_ID_BYTE     = 18'h00008;
   localparam logic [17:0] ADDR_ID_WORD     = 18'h0000A;
   localparam logic [17:0] ADDR_PRESENCE_LO = 18'h10006;
   localparam logic [17:0] ADDR_PRESENCE_HI = 18'h10008;
   localparam logic [17:0] ADDR_IRQ_MAIN    = 18'h10010;
   localparam logic [17:0] ADDR_MGMT_ACK_LG = 18'h10014;
   localparam logic [17:0] ADDR_REV_LG      = 18'h10016;
   localparam logic [17:0] ADDR_STATUS_B3   = 18'h20000;
   localparam logic [17:0] ADDR_STATUS_B2   = 18'h20001;
   localparam logic [17:0] ADDR_STATUS_B1   = 18'h20002;
   localparam logic [17:0] ADDR_STATUS_B0   = 18'h20003;
   localparam logic [17:0] ADDR_MGMT_ACK_SM = 18'h20004;
   localparam logic [17:0] ADDR_EXT_ACK_SM  = 18'h20006;
   localparam logic [17:0] ADDR_IO_MASK     = 18'h20008;
   localparam logic [17:0] ADDR_EXT_ACK_LG  = 18'h2000A;
   localparam logic [17:0] ADDR_IRQ_AUX     = 18'h20010;
   localparam logic [17:0] ADDR_MODEL_ID    = 18'h30000;
   localparam logic [17:0] ADDR_CPU_ID      = 18'h30004;
   localparam logic [17:0] ADDR_ID_BYTE_LG  = 18'h30008;

   localparam logic [31:0] ID_BYTE_VALUE   = 32'h0000_00FF;
   localparam logic [31:0] ID_WORD_VALUE   = 32'h0000_1000;
   localparam logic [31:0] REV_LG_VALUE    = 32'h0000_0012;
   localparam logic [31:0] EXT_ACK_VALUE   = 32'h0000_0054;
   localparam logic [31:0] ALL_ONES_HALF   = 32'h0000_FFFF;
   localparam logic [31:0] MODEL_ID_SMALL  = 32'(4 << 5);
   localparam logic [31:0] MODEL_ID_LARGE  = 32'(3 << 5);
   localparam logic [31:0] CPU_ID_VALUE    = 32'(32 + 1);
   localparam logic [15:0] PRESENCE_SMALL_MASK = 16'h1111;

   typedef struct packed {
      logic [31:0] read_data;
      logic        net_irq;
      logic        mgmt_irq_clear;
      logic        ext_irq_clear;
   } rsp_type;

   function automatic logic [4:0] small_offset(input logic [1:0] slot);
      logic [4:0] r;
      case (slot)
         2'd0:    r = 5'd16;
         2'd1:    r = 5'd24;
         2'd2:    r = 5'd0;
         default: r = 5'd8;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] large_offset(input logic [2:0] slot);
      logic [4:0] r;
      case (slot)
         3'd1:    r = 5'd24;
         3'd2:    r = 5'd16;
         3'd3:    r = 5'd28;
         3'd4:    r = 5'd20;
         3'd5:    r = 5'd8;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] large_mask(input logic [2:0] slot);
      logic [15:0] r;
      case (slot)
         3'd1:    r = 16'hF0FF;
         3'd2:    r = 16'hFFF0;
         3'd3:    r = 16'h0FFF;
         3'd4:    r = 16'hFF0F;
         3'd5:    r = 16'hF0FF;
         3'd6:    r = 16'hFFF0;
         default: r = 16'hFFFF;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/net_irq_status_registers_unit.sv
// A result is written into the result buffer when its item is accepted.
// One item per cycle while the result buffer is not full; the decode and status update take one pass.
// A two-entry result buffer lets items keep flowing while a result waits.
// Synchronous reset clears the status words, the mask register, the card
// presence mask and the result buffer, and sets the chassis model to 1.
`default_nettype none
module net_irq_status_registers_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [17:0] req_address,
   input  wire logic [15:0] req_write_data,
   input  wire logic [2:0]  req_irq_slot,
   input  wire logic [2:0]  req_irq_port,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_net_irq,
   output logic             rsp_mgmt_irq_clear,
   output logic             rsp_ext_irq_clear,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [6:0]  csr_write_data
);
   import nirq_pkg::*;

   logic [1:0]  chassis_model_ff;
   logic [6:0]  card_present_ff;
   logic [31:0] irq_main_ff, irq_main_in;
   logic [31:0] irq_aux_ff, irq_aux_in;
   logic [7:0]  io_mask_ff, io_mask_in;

   rsp_type     buf_ff [2];
   rsp_type     rsp_in;
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   logic        push, pop, is_large, is_read;
   logic        hit, aux_sel;
   logic [5:0]  pos;
   logic [31:0] bit_mask;
   logic [15:0] pres_small, pres_lo, pres_hi;
   logic [6:0]  present;

   assign csr_ready = 1'b1;
   assign req_stall = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign push      = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign is_large  = (chassis_model_ff >= MODEL_LARGE);
   assign is_read   = (req_type == REQ_READ);

   always_comb begin
      for (int n = 0; n < 7; n++) begin
         present[n] = (n < NUM_SLOTS) && card_present_ff[n];
      end
      pres_small = 16'hFFFF;
      for (int n = 0; n < 4; n++) begin
         if (present[n]) begin
            pres_small = pres_small & ~(PRESENCE_SMALL_MASK << n);
         end
      end
      pres_lo = 16'hFFFF;
      for (int n = 1; n <= 4; n++) begin
         if (present[n]) begin
            pres_lo = pres_lo & large_mask(3'(n));
         end
      end
      pres_hi = 16'hFFFF;
      for (int n = 5; n <= 6; n++) begin
         if (present[n]) begin
            pres_hi = pres_hi & large_mask(3'(n));
         end
      end
   end

   always_comb begin
      hit     = 1'b0;
      aux_sel = 1'b0;
      pos     = '0;
      if (32'(req_irq_slot) < NUM_SLOTS) begin
         if (is_large) begin
            aux_sel = (req_irq_slot == 3'd0);
            pos     = {1'b0, large_offset(req_irq_slot)} + {3'b000, req_irq_port};
            hit     = (pos <= 6'd31);
         end else if (req_irq_slot < 3'd4) begin
            pos = {1'b0, small_offset(req_irq_slot[1:0])} + {3'b000, req_irq_port};
            hit = (pos <= 6'd31);
         end
      end
      bit_mask = 32'd1 << pos[4:0];
   end

   always_comb begin
      irq_main_in = irq_main_ff;
      irq_aux_in  = irq_aux_ff;
      io_mask_in  = io_mask_ff;
      rsp_in      = '0;
      case (req_type)
         REQ_IRQ_SET: begin
            if (hit && aux_sel) irq_aux_in = irq_aux_ff | bit_mask;
            if (hit && !aux_sel) irq_main_in = irq_main_ff | bit_mask;
         end
         REQ_IRQ_CLEAR: begin
            if (hit && aux_sel) irq_aux_in = irq_aux_ff & ~bit_mask;
            if (hit && !aux_sel) irq_main_in = irq_main_ff & ~bit_mask;
         end
         default: begin
            if (!is_large) begin
               unique case (req_address)
                  ADDR_ID_BYTE:     if (is_read) rsp_in.read_data = ID_BYTE_VALUE;
                  ADDR_ID_WORD:     if (is_read) rsp_in.read_data = ID_WORD_VALUE;
                  ADDR_PRESENCE_LO: if (is_read) rsp_in.read_data = {16'h0, pres_small};
                  ADDR_STATUS_B3:   if (is_read) rsp_in.read_data = {24'h0, irq_main_ff[31:24]};
                  ADDR_STATUS_B2:   if (is_read) rsp_in.read_data = {24'h0, irq_main_ff[23:16]};
                  ADDR_STATUS_B1:   if (is_read) rsp_in.read_data = {24'h0, irq_main_ff[15:8]};
                  ADDR_STATUS_B0:   if (is_read) rsp_in.read_data = {24'h0, irq_main_ff[7:0]};
                  ADDR_MGMT_ACK_SM: rsp_in.mgmt_irq_clear = 1'b1;
                  ADDR_EXT_ACK_SM:  rsp_in.ext_irq_clear = 1'b1;
                  ADDR_IO_MASK: begin
                     if (is_read) rsp_in.read_data = {24'h0, io_mask_ff};
                     else io_mask_in = req_write_data[7:0];
                  end
                  ADDR_MODEL_ID: begin
                     if (is_read && chassis_model_ff == MODEL_SMALL) begin
                        rsp_in.read_data = MODEL_ID_SMALL;
                     end
                  end
                  ADDR_CPU_ID:      if (is_read) rsp_in.read_data = CPU_ID_VALUE;
                  default: ;
               endcase
            end else begin
               unique case (req_address)
                  ADDR_ID_BYTE, ADDR_ID_BYTE_LG: begin
                     if (is_read) rsp_in.read_data = ID_BYTE_VALUE;
                  end
                  ADDR_ID_WORD:     if (is_read) rsp_in.read_data = ID_WORD_VALUE;
                  ADDR_PRESENCE_LO: if (is_read) rsp_in.read_data = {16'h0, pres_lo};
                  ADDR_PRESENCE_HI: if (is_read) rsp_in.read_data = {16'h0, pres_hi};
                  ADDR_REV_LG:      if (is_read) rsp_in.read_data = REV_LG_VALUE;
                  ADDR_STATUS_B3, ADDR_STATUS_B1, ADDR_MGMT_ACK_SM: begin
                     if (is_read) rsp_in.read_data = ALL_ONES_HALF;
                  end
                  ADDR_IO_MASK: begin
                     if (is_read) rsp_in.read_data = {24'h0, io_mask_ff};
                     else io_mask_in = req_write_data[7:0];
                  end
                  ADDR_MODEL_ID:    if (is_read) rsp_in.read_data = MODEL_ID_LARGE;
                  ADDR_CPU_ID:      if (is_read) rsp_in.read_data = CPU_ID_VALUE;
                  ADDR_IRQ_MAIN:    if (is_read) rsp_in.read_data = irq_main_ff;
                  ADDR_IRQ_AUX:     if (is_read) rsp_in.read_data = irq_aux_ff;
                  ADDR_MGMT_ACK_LG: rsp_in.mgmt_irq_clear = 1'b1;
                  ADDR_EXT_ACK_LG: begin
                     if (is_read) rsp_in.read_data = EXT_ACK_VALUE;
                     rsp_in.ext_irq_clear = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
      endcase
      if (is_large) rsp_in.net_irq = ((irq_main_in | irq_aux_in) != 32'h0);
      else rsp_in.net_irq = (irq_main_in != 32'h0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chassis_model_ff <= MODEL_MEDIUM;
         card_present_ff  <= '0;
         irq_main_ff      <= '0;
         irq_aux_ff       <= '0;
         io_mask_ff       <= '0;
         wr_ptr_ff        <= 1'b0;
         rd_ptr_ff        <= 1'b0;
         count_ff         <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_CHASSIS_MODEL: chassis_model_ff <= csr_write_data[1:0];
               CSR_CARD_PRESENT:  card_present_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (push) begin
            irq_main_ff <= irq_main_in;
            irq_aux_ff  <= irq_aux_in;
            io_mask_ff  <= io_mask_in;
            wr_ptr_ff   <= !wr_ptr_ff;
         end
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) buf_ff[wr_ptr_ff] <= rsp_in;
   end

   assign rsp_read_data      = buf_ff[rd_ptr_ff].read_data;
   assign rsp_net_irq        = buf_ff[rd_ptr_ff].net_irq;
   assign rsp_mgmt_irq_clear = buf_ff[rd_ptr_ff].mgmt_irq_clear;
   assign rsp_ext_irq_clear  = buf_ff[rd_ptr_ff].ext_irq_clear;

endmodule
`default_nettype wire

>>> sim/tb_net_irq_status_registers_unit.sv
module tb_net_irq_status_registers_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import nirq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_READ;
   logic [17:0] req_address = '0;
   logic [15:0] req_write_data = '0;
   logic [2:0]  req_irq_slot = '0;
   logic [2:0]  req_irq_port = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_net_irq;
   logic        rsp_mgmt_irq_clear;
   logic        rsp_ext_irq_clear;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_CHASSIS_MODEL;
   logic [6:0]  csr_write_data = '0;

   logic [1:0]  chassis_q;
   logic [6:0]  present_q;
   logic [31:0] main_word;
   logic [31:0] aux_word;
   logic [7:0]  mask_byte;

   rsp_type     status_expected[$];
   rsp_type     want;
   int          mismatches = 0;
   bit          no_idle = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;

   net_irq_status_registers_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_address(req_address),
      .req_write_data(req_write_data),
      .req_irq_slot(req_irq_slot),
      .req_irq_port(req_irq_port),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_read_data(rsp_read_data),
      .rsp_net_irq(rsp_net_irq),
      .rsp_mgmt_irq_clear(rsp_mgmt_irq_clear),
      .rsp_ext_irq_clear(rsp_ext_irq_clear),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] presence_large(input int first, input int last);
      logic [15:0] p;
      logic [15:0] m;
      p = 16'hFFFF;
      for (int n = first; n <= last; n++) begin
         case (n)
            1, 5:    m = 16'hF0FF;
            2, 6:    m = 16'hFFF0;
            3:       m = 16'h0FFF;
            default: m = 16'hFF0F;
         endcase
         if (present_q[n]) p &= m;
      end
      return p;
   endfunction

   function automatic rsp_type predict_status(input req_kind_type kind,
                                              input logic [17:0] addr,
                                              input logic [15:0] wdata,
                                              input logic [2:0] slot,
                                              input logic [2:0] port);
      rsp_type     r;
      logic        wide_map;
      logic        rd;
      logic        mapped;
      logic        use_aux;
      int          pos;
      logic [15:0] p;
      r = '0;
      wide_map = (chassis_q >= MODEL_LARGE);
      rd = (kind == REQ_READ);
      if (kind == REQ_IRQ_SET || kind == REQ_IRQ_CLEAR) begin
         mapped = 1'b1;
         use_aux = 1'b0;
         pos = 0;
         if (slot >= NUM_SLOTS) begin
            mapped = 1'b0;
         end else if (wide_map) begin
            use_aux = (slot == 3'd0);
            case (slot)
               3'd1:    pos = 24;
               3'd2:    pos = 16;
               3'd3:    pos = 28;
               3'd4:    pos = 20;
               3'd5:    pos = 8;
               default: pos = 0;
            endcase
         end else begin
            case (slot)
               3'd0:    pos = 16;
               3'd1:    pos = 24;
               3'd2:    pos = 0;
               3'd3:    pos = 8;
               default: mapped = 1'b0;
            endcase
         end
         pos = pos + port;
         if (mapped && pos <= 31) begin
            if (use_aux) aux_word[pos] = (kind == REQ_IRQ_SET);
            else main_word[pos] = (kind == REQ_IRQ_SET);
         end
      end else if (!wide_map) begin
         case (addr)
            ADDR_ID_BYTE: if (rd) r.read_data = ID_BYTE_VALUE;
            ADDR_ID_WORD: if (rd) r.read_data = ID_WORD_VALUE;
            ADDR_PRESENCE_LO: begin
               p = 16'hFFFF;
               for (int n = 0; n < 4; n++)
                  if (present_q[n]) p &= ~(PRESENCE_SMALL_MASK << n);
               if (rd) r.read_data = {16'h0, p};
            end
            ADDR_STATUS_B3: if (rd) r.read_data = {24'h0, main_word[31:24]};
            ADDR_STATUS_B2: if (rd) r.read_data = {24'h0, main_word[23:16]};
            ADDR_STATUS_B1: if (rd) r.read_data = {24'h0, main_word[15:8]};
            ADDR_STATUS_B0: if (rd) r.read_data = {24'h0, main_word[7:0]};
            ADDR_MGMT_ACK_SM: r.mgmt_irq_clear = 1'b1;
            ADDR_EXT_ACK_SM: r.ext_irq_clear = 1'b1;
            ADDR_IO_MASK: begin
               if (rd) r.read_data = {24'h0, mask_byte};
               else mask_byte = wdata[7:0];
            end
            ADDR_MODEL_ID:
               if (rd) r.read_data = (chassis_q == MODEL_SMALL) ? MODEL_ID_SMALL : '0;
            ADDR_CPU_ID: if (rd) r.read_data = CPU_ID_VALUE;
            default: ;
         endcase
      end else begin
         case (addr)
            ADDR_ID_BYTE, ADDR_ID_BYTE_LG: if (rd) r.read_data = ID_BYTE_VALUE;
            ADDR_ID_WORD: if (rd) r.read_data = ID_WORD_VALUE;
            ADDR_PRESENCE_LO: if (rd) r.read_data = {16'h0, presence_large(1, 4)};
            ADDR_PRESENCE_HI: if (rd) r.read_data = {16'h0, presence_large(5, 6)};
            ADDR_REV_LG: if (rd) r.read_data = REV_LG_VALUE;
            ADDR_STATUS_B3, ADDR_STATUS_B1, ADDR_MGMT_ACK_SM:
               if (rd) r.read_data = ALL_ONES_HALF;
            ADDR_IO_MASK: begin
               if (rd) r.read_data = {24'h0, mask_byte};
               else mask_byte = wdata[7:0];
            end
            ADDR_MODEL_ID: if (rd) r.read_data = MODEL_ID_LARGE;
            ADDR_CPU_ID: if (rd) r.read_data = CPU_ID_VALUE;
            ADDR_IRQ_MAIN: if (rd) r.read_data = main_word;
            ADDR_IRQ_AUX: if (rd) r.read_data = aux_word;
            ADDR_MGMT_ACK_LG: r.mgmt_irq_clear = 1'b1;
            ADDR_EXT_ACK_LG: begin
               if (rd) r.read_data = EXT_ACK_VALUE;
               r.ext_irq_clear = 1'b1;
            end
            default: ;
         endcase
      end
      r.net_irq = wide_map ? ((main_word | aux_word) != 0) : (main_word != 0);
      return r;
   endfunction

   task automatic send_item(input req_kind_type kind, input logic [17:0] addr,
                            input logic [15:0] wdata, input logic [2:0] slot,
                            input logic [2:0] port);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(99) < 12) gap = 1;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_address <= addr;
      req_write_data <= wdata;
      req_irq_slot <= slot;
      req_irq_port <= port;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      status_expected.push_back(predict_status(kind, addr, wdata, slot, port));
   endtask

   task automatic send_random_item;
      int           pick;
      req_kind_type kind;
      logic [17:0]  addr;
      pick = $urandom_range(99);
      if (pick < 40) kind = REQ_READ;
      else if (pick < 55) kind = REQ_WRITE;
      else if (pick < 80) kind = REQ_IRQ_SET;
      else kind = REQ_IRQ_CLEAR;
      if ($urandom_range(99) < 80) begin
         case ($urandom_range(18))
            0:  addr = ADDR_ID_BYTE;
            1:  addr = ADDR_ID_WORD;
            2:  addr = ADDR_PRESENCE_LO;
            3:  addr = ADDR_PRESENCE_HI;
            4:  addr = ADDR_IRQ_MAIN;
            5:  addr = ADDR_MGMT_ACK_LG;
            6:  addr = ADDR_REV_LG;
            7:  addr = ADDR_STATUS_B3;
            8:  addr = ADDR_STATUS_B2;
            9:  addr = ADDR_STATUS_B1;
            10: addr = ADDR_STATUS_B0;
            11: addr = ADDR_MGMT_ACK_SM;
            12: addr = ADDR_EXT_ACK_SM;
            13: addr = ADDR_IO_MASK;
            14: addr = ADDR_EXT_ACK_LG;
            15: addr = ADDR_IRQ_AUX;
            16: addr = ADDR_MODEL_ID;
            17: addr = ADDR_CPU_ID;
            default: addr = ADDR_ID_BYTE_LG;
         endcase
      end else begin
         addr = 18'($urandom);
      end
      send_item(kind, addr, 16'($urandom), 3'($urandom_range(7)), 3'($urandom_range(7)));
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [6:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_CHASSIS_MODEL) chassis_q = data[1:0];
      else present_q = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle;
      @(negedge clock);
      req_valid <= 1'b0;
      while (status_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_small_map;
      send_item(REQ_IRQ_SET, '0, '0, 3'd0, 3'd7);
      send_item(REQ_IRQ_SET, '0, '0, 3'd3, 3'd0);
      send_item(REQ_IRQ_SET, '0, '0, 3'd4, 3'd0);
      send_item(REQ_IRQ_SET, '0, 16'hFFFF, 3'd7, 3'd7);
      send_item(REQ_READ, ADDR_STATUS_B1, '0, '0, '0);
      send_item(REQ_READ, ADDR_STATUS_B2, '0, '0, '0);
      send_item(REQ_WRITE, ADDR_IO_MASK, 16'hFFFF, '0, '0);
      send_item(REQ_READ, ADDR_IO_MASK, '0, '0, '0);
      send_item(REQ_WRITE, ADDR_MGMT_ACK_SM, '0, '0, '0);
      send_item(REQ_READ, ADDR_EXT_ACK_SM, '0, '0, '0);
      send_item(REQ_READ, ADDR_MODEL_ID, '0, '0, '0);
      send_item(REQ_READ, 18'h3FFFF, '0, '0, '0);
      send_item(REQ_IRQ_CLEAR, '0, '0, 3'd0, 3'd7);
   endtask

   task automatic test_large_map;
      wait_idle();
      write_csr(CSR_CHASSIS_MODEL, {5'd0, MODEL_LARGE});
      write_csr(CSR_CARD_PRESENT, 7'h7F);
      send_item(REQ_IRQ_SET, '0, '0, 3'd3, 3'd7);
      send_item(REQ_IRQ_SET, '0, '0, 3'd0, 3'd7);
      send_item(REQ_READ, ADDR_IRQ_AUX, '0, '0, '0);
      send_item(REQ_READ, ADDR_IRQ_MAIN, '0, '0, '0);
      send_item(REQ_READ, ADDR_PRESENCE_LO, '0, '0, '0);
      send_item(REQ_READ, ADDR_PRESENCE_HI, '0, '0, '0);
      send_item(REQ_READ, ADDR_EXT_ACK_LG, '0, '0, '0);
      send_item(REQ_WRITE, ADDR_MGMT_ACK_LG, '0, '0, '0);
      send_item(REQ_WRITE, ADDR_IRQ_MAIN, 16'hFFFF, '0, '0);
      send_item(REQ_READ, 18'h00000, '0, '0, '0);
      send_item(REQ_IRQ_CLEAR, '0, '0, 3'd3, 3'd0);
   endtask

   task automatic test_back_to_back;
      no_idle = 1'b1;
      repeat (200) send_random_item();
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure;
      no_idle = 1'b1;
      hold_request = 1'b1;
      repeat (80) send_random_item();
      no_idle = 1'b0;
   endtask

   task automatic test_random_phases;
      logic [6:0] present;
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         if (phase == 0) present = 7'h7F;
         else if (phase == 1) present = 7'h00;
         else present = 7'($urandom);
         write_csr(CSR_CHASSIS_MODEL, {5'($urandom), 2'(phase % 4)});
         write_csr(CSR_CARD_PRESENT, present);
         repeat (155) send_random_item();
      end
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 150;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99) < 11);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_expected.size() == 0) begin
            $error("result with no item waiting: read_data %h", rsp_read_data);
            mismatches++;
         end else begin
            want = status_expected.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("read_data expected %h actual %h", want.read_data, rsp_read_data);
               mismatches++;
            end
            if (rsp_net_irq !== want.net_irq) begin
               $error("net_irq expected %b actual %b", want.net_irq, rsp_net_irq);
               mismatches++;
            end
            if (rsp_mgmt_irq_clear !== want.mgmt_irq_clear) begin
               $error("mgmt_irq_clear expected %b actual %b", want.mgmt_irq_clear,
                      rsp_mgmt_irq_clear);
               mismatches++;
            end
            if (rsp_ext_irq_clear !== want.ext_irq_clear) begin
               $error("ext_irq_clear expected %b actual %b", want.ext_irq_clear,
                      rsp_ext_irq_clear);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      chassis_q = MODEL_MEDIUM;
      present_q = '0;
      main_word = '0;
      aux_word = '0;
      mask_byte = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_small_map();
      test_large_map();
      test_back_to_back();
      test_backpressure();
      test_random_phases();
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && status_expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/nirq_pkg.sv
sv/net_irq_status_registers_unit.sv
sim/tb_net_irq_status_registers_unit.sv
